// ===== sv/ibbw_pkg.sv =====
// ibbw_pkg: shared constants, opcode and state enums for the interleaved bit/byte writer.
// No dependencies; imported by interleaved_bit_byte_writer, ibbw_checker and the bench.
package ibbw_pkg;

  localparam int MAX_BYTES = 1024;
  localparam int ADDR_W    = $clog2(MAX_BYTES);
  localparam int BCNT_W    = ADDR_W + 1;
  localparam int BPOS_W    = BCNT_W + 3;

  // Opcodes of an input word
  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_BITS  = 3'd1,
    OP_BIT   = 3'd2,
    OP_BYTE  = 3'd3,
    OP_SHORT = 3'd4,
    OP_LONG  = 3'd5,
    OP_READ  = 3'd6,
    OP_NOP   = 3'd7
  } op_e;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_BITS  = 4'b0010,
    S_BYTES = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

endpackage

// ===== sv/interleaved_bit_byte_writer.sv =====
// interleaved_bit_byte_writer: LSB-first bit packer with little-endian byte appends.
// Depends on ibbw_pkg (constants, opcode and state enums).
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------------------
//  command  | start_i / busy_o          | opcode_i, value_i, bit_count_i, read_index_i
//  result   | done_o (one-cycle strobe) | overflowed_o, used_bytes_o, used_bits_o,
//           |                           | read_data_o
//  config   | cfg_we_i                  | cfg_wdata_i (capacity)
//
// Clear, read, nop, zero-count and rejected writes go straight to the result strobe. A
// bit-field write enters the buffer one bit per cycle (count capped at 32), as does a
// single bit; byte, short and long appends write one buffer byte per cycle through the
// single buffer write port. Reset clears counts, flag and capacity (to 1024); buffer
// contents are not cleared. The result strobe cannot be stalled.
module interleaved_bit_byte_writer
  import ibbw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [2:0]        opcode_i,
  input  logic [31:0]       value_i,
  input  logic [5:0]        bit_count_i,
  input  logic [9:0]        read_index_i,
  output logic              done_o,
  output logic              overflowed_o,
  output logic [10:0]       used_bytes_o,
  output logic [13:0]       used_bits_o,
  output logic [7:0]        read_data_o,
  input  logic              cfg_we_i,
  input  logic [10:0]       cfg_wdata_i
);

  state_e              state_q, state_d;
  logic [BCNT_W-1:0]   bc_q, bc_d;
  logic [BPOS_W-1:0]   bp_q, bp_d;
  logic                ovf_q, ovf_d;
  logic [10:0]         cap_q;
  logic [5:0]          cnt_q, cnt_d;
  logic [31:0]         val_q, val_d;
  logic [7:0]          shadow_q, shadow_d;
  logic                hit_q, hit_d;
  logic [7:0]          rd_q;

  logic                accept;
  logic [BCNT_W-1:0]   limit;
  logic [BCNT_W:0]     bc_ext;
  logic [5:0]          cnt_sat;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [7:0]          mem_wdata;
  logic [2:0]          pad;
  logic [7:0]          mem_q [MAX_BYTES];

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  // Limit saturates at the buffer size
  assign limit   = (cap_q > 11'(MAX_BYTES)) ? BCNT_W'(MAX_BYTES) : BCNT_W'(cap_q);
  assign bc_ext  = {1'b0, bc_q};
  assign cnt_sat = (bit_count_i > 6'd32) ? 6'd32 : bit_count_i;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    bc_d      = bc_q;
    bp_d      = bp_q;
    ovf_d     = ovf_q;
    cnt_d     = cnt_q;
    val_d     = val_q;
    shadow_d  = shadow_q;
    hit_d     = hit_q;
    mem_we    = 1'b0;
    mem_waddr = bc_q[ADDR_W-1:0];
    mem_wdata = val_q[7:0];
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          hit_d   = 1'b0;
          val_d   = value_i;
          state_d = S_DONE;
          case (op_e'(opcode_i))
            OP_CLEAR: begin
              bc_d  = '0;
              bp_d  = '0;
              ovf_d = 1'b0;
            end
            OP_BITS: begin
              if (bc_ext + (BCNT_W+1)'(4) > {1'b0, limit}) begin
                ovf_d = 1'b1;
              end else if (cnt_sat != 6'd0) begin
                cnt_d   = cnt_sat;
                state_d = S_BITS;
              end
            end
            OP_BIT: begin
              if ((bp_q[2:0] == 3'd0) && (bc_q >= limit)) begin
                ovf_d = 1'b1;
              end else begin
                cnt_d   = 6'd1;
                val_d   = 32'd1;
                state_d = S_BITS;
              end
            end
            OP_BYTE, OP_SHORT, OP_LONG: begin
              if (op_e'(opcode_i) == OP_BYTE)       cnt_d = 6'd1;
              else if (op_e'(opcode_i) == OP_SHORT) cnt_d = 6'd2;
              else                                  cnt_d = 6'd4;
              if (bc_ext + (BCNT_W+1)'(cnt_d) > {1'b0, limit}) begin
                ovf_d = 1'b1;
              end else begin
                state_d = S_BYTES;
              end
            end
            OP_READ: begin
              hit_d = ({1'b0, read_index_i} < bc_q);
            end
            default: ;
          endcase
        end
      end
      // One bit per cycle; the byte holding the bit position is mirrored in shadow
      S_BITS: begin
        mem_we = 1'b1;
        if (bp_q[2:0] == 3'd0) begin
          shadow_d  = {7'd0, val_q[0]};
          mem_waddr = bc_q[ADDR_W-1:0];
          bp_d      = {bc_q, 3'd0} + BPOS_W'(1);
          bc_d      = bc_q + BCNT_W'(1);
        end else begin
          shadow_d  = shadow_q | (8'(val_q[0]) << bp_q[2:0]);
          mem_waddr = bp_q[ADDR_W+2:3];
          bp_d      = bp_q + BPOS_W'(1);
        end
        mem_wdata = shadow_d;
        val_d     = {1'b0, val_q[31:1]};
        cnt_d     = cnt_q - 6'd1;
        if (cnt_q == 6'd1) state_d = S_DONE;
      end
      // One byte per cycle, little-endian
      S_BYTES: begin
        mem_we    = 1'b1;
        mem_waddr = bc_q[ADDR_W-1:0];
        mem_wdata = val_q[7:0];
        bc_d      = bc_q + BCNT_W'(1);
        val_d     = {8'd0, val_q[31:8]};
        cnt_d     = cnt_q - 6'd1;
        if (cnt_q == 6'd1) state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and status registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      bc_q    <= '0;
      bp_q    <= '0;
      ovf_q   <= 1'b0;
      cap_q   <= 11'(MAX_BYTES);
      cnt_q   <= '0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      bc_q    <= bc_d;
      bp_q    <= bp_d;
      ovf_q   <= ovf_d;
      cnt_q   <= cnt_d;
      hit_q   <= hit_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    shadow_q <= shadow_d;
  end

  // Buffer memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (accept) rd_q <= mem_q[read_index_i];
  end

  // Result outputs
  assign pad          = 3'd0 - bp_q[2:0];
  assign done_o       = (state_q == S_DONE);
  assign overflowed_o = ovf_q;
  assign used_bytes_o = bc_q;
  assign used_bits_o  = {bc_q, 3'd0} - {11'd0, pad};
  assign read_data_o  = hit_q ? rd_q : 8'd0;

  // Checks
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted word did not raise busy");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && opcode_i == OP_CLEAR) |=>
      (used_bytes_o == 11'd0) && !overflowed_o && (used_bits_o == 14'd0))
    else $error("clear left state behind");

  a_bits_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (used_bits_o <= {used_bytes_o, 3'd0}))
    else $error("bit count exceeds allocated bytes");

endmodule

// ===== dv/ibbw_checker.sv =====
`timescale 1ns / 100ps
// ibbw_checker: predicts the status word of interleaved_bit_byte_writer and checks each one.
// Depends on ibbw_pkg; watches the command, config and status ports beside the block.
module ibbw_checker
  import ibbw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [2:0]  opcode_i,
  input  logic [31:0] value_i,
  input  logic [5:0]  bit_count_i,
  input  logic [9:0]  read_index_i,
  input  logic        done_i,
  input  logic        overflowed_i,
  input  logic [10:0] used_bytes_i,
  input  logic [13:0] used_bits_i,
  input  logic [7:0]  read_data_i,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  output int          fail_count_o,
  output int          open_count_o
);

  typedef struct packed {
    logic        ovf;
    logic [10:0] used_bytes;
    logic [13:0] used_bits;
    logic [7:0]  rdata;
  } status_t;

  // Mirror of the message buffer and its counters
  logic [7:0]  msg_mem [MAX_BYTES];
  int unsigned nbytes;
  int unsigned bpos;
  logic        ovf;
  int unsigned cap;

  status_t status_due_q [$];
  int          n_fail = 0;

  assign fail_count_o = n_fail;

  function automatic int limit_bytes();
    return (cap > MAX_BYTES) ? MAX_BYTES : int'(cap);
  endfunction

  // Fresh zeroed byte at the end of the buffer for bit packing
  function automatic void open_bit_byte();
    bpos = 8 * nbytes;
    msg_mem[10'(nbytes)] = 8'h00;
    nbytes++;
  endfunction

  // Little-endian append of n bytes, dropped whole if it does not fit
  function automatic void append_le(logic [31:0] v, int n);
    if (int'(nbytes) + n > limit_bytes()) begin
      ovf = 1'b1;
    end else begin
      for (int i = 0; i < n; i++) begin
        msg_mem[10'(nbytes)] = v[7:0];
        nbytes++;
        v = v >> 8;
      end
    end
  endfunction

  // Applies one command word to the mirror and returns the status it should report
  function automatic status_t pack_command(op_e op, logic [31:0] val, logic [5:0] cnt_in,
                                           logic [9:0] ridx);
    int unsigned cnt;
    int unsigned sh;
    logic [31:0] v;
    logic [7:0]  rd;
    logic [31:0] ub;
    status_t     s;
    cnt = 32'(cnt_in);
    v   = val;
    rd  = 8'h00;
    case (op)
      OP_CLEAR: begin
        nbytes = 0;
        bpos   = 0;
        ovf    = 1'b0;
      end
      OP_BITS: begin
        if (cnt > 32) cnt = 32;
        // needs four free bytes even for a zero count
        if (limit_bytes() - int'(nbytes) >= 4) begin
          repeat (cnt) begin
            sh = bpos % 8;
            if (sh == 0) open_bit_byte();
            if (v[0]) msg_mem[10'(bpos / 8)][3'(sh)] = 1'b1;
            bpos++;
            v = v >> 1;
          end
        end else begin
          ovf = 1'b1;
        end
      end
      OP_BIT: begin
        sh = bpos % 8;
        // space is checked only when a new byte must be opened
        if (sh == 0 && int'(nbytes) >= limit_bytes()) begin
          ovf = 1'b1;
        end else begin
          if (sh == 0) open_bit_byte();
          msg_mem[10'(bpos / 8)][3'(sh)] = 1'b1;
          bpos++;
        end
      end
      OP_BYTE:  append_le(val, 1);
      OP_SHORT: append_le(val, 2);
      OP_LONG:  append_le(val, 4);
      OP_READ: begin
        if (ridx < nbytes) rd = msg_mem[ridx];
      end
      default: ;
    endcase
    ub = 8 * nbytes - ((8 - (bpos % 8)) % 8);
    s.ovf        = ovf;
    s.used_bytes = nbytes[10:0];
    s.used_bits  = ub[13:0];
    s.rdata      = rd;
    return s;
  endfunction

  // Watch the channels: config first, then the status strobe, then a new command word
  always @(posedge clk_i or negedge rst_ni) begin
    status_t want;
    if (!rst_ni) begin
      nbytes = 0;
      bpos   = 0;
      ovf    = 1'b0;
      cap    = 1024;
      status_due_q.delete();
      open_count_o <= 0;
    end else begin
      if (cfg_we_i) cap = 32'(cfg_wdata_i);
      if (done_i) begin
        if (status_due_q.size() == 0) begin
          $error("status word with none due");
          n_fail++;
        end else begin
          want = status_due_q.pop_front();
          if (overflowed_i !== want.ovf) begin
            $error("overflowed: expected %0d, actual %0d", want.ovf, overflowed_i);
            n_fail++;
          end
          if (used_bytes_i !== want.used_bytes) begin
            $error("used_bytes: expected %0d, actual %0d", want.used_bytes, used_bytes_i);
            n_fail++;
          end
          if (used_bits_i !== want.used_bits) begin
            $error("used_bits: expected %0d, actual %0d", want.used_bits, used_bits_i);
            n_fail++;
          end
          if (read_data_i !== want.rdata) begin
            $error("read_data: expected 0x%02h, actual 0x%02h", want.rdata, read_data_i);
            n_fail++;
          end
        end
      end
      if (start_i && !busy_i) begin
        status_due_q.push_back(pack_command(op_e'(opcode_i), value_i, bit_count_i,
                                            read_index_i));
      end
      open_count_o <= status_due_q.size();
    end
  end

endmodule

// ===== dv/interleaved_bit_byte_writer_tb.sv =====
`timescale 1ns / 100ps
// interleaved_bit_byte_writer_tb: directed and random command words with capacity phases.
// Depends on ibbw_pkg, interleaved_bit_byte_writer and ibbw_checker.
module interleaved_bit_byte_writer_tb;
  import ibbw_pkg::*;

  localparam int HALF_NS = 4;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        start_i      = 1'b0;
  logic [2:0]  opcode_i     = '0;
  logic [31:0] value_i      = '0;
  logic [5:0]  bit_count_i  = '0;
  logic [9:0]  read_index_i = '0;
  logic        cfg_we_i     = 1'b0;
  logic [10:0] cfg_wdata_i  = '0;
  logic        busy_o;
  logic        done_o;
  logic        overflowed_o;
  logic [10:0] used_bytes_o;
  logic [13:0] used_bits_o;
  logic [7:0]  read_data_o;
  int          fail_count;
  int          open_count;

  always begin
    #(HALF_NS) clk_i = 1'b1;
    #(HALF_NS) clk_i = 1'b0;
  end

  interleaved_bit_byte_writer u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .opcode_i     (opcode_i),
    .value_i      (value_i),
    .bit_count_i  (bit_count_i),
    .read_index_i (read_index_i),
    .done_o       (done_o),
    .overflowed_o (overflowed_o),
    .used_bytes_o (used_bytes_o),
    .used_bits_o  (used_bits_o),
    .read_data_o  (read_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  ibbw_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .opcode_i     (opcode_i),
    .value_i      (value_i),
    .bit_count_i  (bit_count_i),
    .read_index_i (read_index_i),
    .done_i       (done_o),
    .overflowed_i (overflowed_o),
    .used_bytes_i (used_bytes_o),
    .used_bits_i  (used_bits_o),
    .read_data_i  (read_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .open_count_o (open_count)
  );

  // Drop start and idle for the length given by n; an n of zero leaves start as it is
  task automatic pause(input int n);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Mostly back to back, some short gaps, a few long ones
  task automatic random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)      pause(0);
    else if (r < 90) pause($urandom_range(1, 3));
    else             pause($urandom_range(8, 40));
  endtask

  // Present one command word and hold it until the block takes it
  task automatic cmd(input op_e op, input logic [31:0] val, input logic [5:0] cnt,
                     input logic [9:0] ridx);
    start_i      <= 1'b1;
    opcode_i     <= op;
    value_i      <= val;
    bit_count_i  <= cnt;
    read_index_i <= ridx;
    do @(posedge clk_i); while (busy_o);
    random_gap();
  endtask

  // Wait until every status word has come back and the block is idle
  task automatic settle();
    start_i <= 1'b0;
    do @(posedge clk_i); while (open_count != 0 || busy_o);
  endtask

  task automatic set_capacity(input logic [10:0] v);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // One random word; the fill mix favors appends and wide fields so the buffer fills up
  task automatic random_cmd(input bit fill);
    int          r;
    int          used;
    op_e         op;
    logic [31:0] val;
    logic [5:0]  cnt;
    logic [9:0]  ridx;
    r    = $urandom_range(0, 99);
    used = int'(used_bytes_o);
    if (fill) begin
      if (r < 40)      op = OP_LONG;
      else if (r < 55) op = OP_SHORT;
      else if (r < 75) op = OP_BITS;
      else if (r < 80) op = OP_BIT;
      else             op = OP_READ;
    end else begin
      if (r < 3)       op = OP_CLEAR;
      else if (r < 33) op = OP_BITS;
      else if (r < 53) op = OP_BIT;
      else if (r < 65) op = OP_BYTE;
      else if (r < 75) op = OP_SHORT;
      else if (r < 85) op = OP_LONG;
      else if (r < 98) op = OP_READ;
      else             op = OP_NOP;
    end
    r = $urandom_range(0, 9);
    if (r == 0)      val = 32'h0000_0000;
    else if (r == 1) val = 32'hFFFF_FFFF;
    else             val = $urandom();
    r = $urandom_range(0, 9);
    if (fill)        cnt = 6'd32;
    else if (r < 7)  cnt = 6'($urandom_range(0, 32));
    else if (r == 7) cnt = (($urandom_range(0, 1) == 0) ? 6'd0 : 6'd32);
    else             cnt = 6'($urandom_range(0, 63));
    if ($urandom_range(0, 9) < 6)
      ridx = 10'($urandom_range(0, (used + 2 > 1023) ? 1023 : used + 2));
    else
      ridx = 10'($urandom_range(0, 1023));
    cmd(op, val, cnt, ridx);
  endtask

  initial begin
    logic [10:0] caps [12];
    caps = '{11'd1024, 11'd5, 11'd2047, 11'd0, 11'd40, 11'd1024, 11'd1024, 11'd0,
             11'd4, 11'd1, 11'd0, 11'd1024};
    caps[7]  = 11'($urandom_range(0, 2047));
    caps[10] = 11'($urandom_range(0, 2047));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset capacity, empty reads, bit and byte interleave, saturated count
    cmd(OP_READ,  32'h0,         6'd0,  10'd0);
    cmd(OP_READ,  32'h0,         6'd0,  10'd1023);
    cmd(OP_BITS,  32'hFFFF_FFFF, 6'd0,  10'd0);
    cmd(OP_BIT,   32'h0,         6'd0,  10'd0);
    cmd(OP_BITS,  32'hFFFF_FFFF, 6'd32, 10'd0);
    cmd(OP_BITS,  32'h8000_0001, 6'd63, 10'd0);
    cmd(OP_BYTE,  32'hFFFF_FF5A, 6'd0,  10'd0);
    cmd(OP_SHORT, 32'h1234_BEEF, 6'd0,  10'd0);
    cmd(OP_LONG,  32'hFFFF_FFFF, 6'd0,  10'd0);
    cmd(OP_BIT,   32'h0,         6'd0,  10'd0);
    cmd(OP_BITS,  32'h0000_0055, 6'd7,  10'd0);
    cmd(OP_READ,  32'h0,         6'd0,  10'd5);
    cmd(OP_READ,  32'h0,         6'd0,  10'd12);
    cmd(OP_NOP,   32'hFFFF_FFFF, 6'd63, 10'd1023);
    cmd(OP_CLEAR, 32'h0,         6'd0,  10'd0);
    // small buffer: multi-bit needs four free bytes, flag stays after a fitting write
    set_capacity(11'd6);
    cmd(OP_LONG,  32'h0102_0304, 6'd0,  10'd0);
    cmd(OP_BITS,  32'h1,         6'd1,  10'd0);
    cmd(OP_BIT,   32'h0,         6'd0,  10'd0);
    cmd(OP_SHORT, 32'hA5A5,      6'd0,  10'd0);
    cmd(OP_BYTE,  32'h77,        6'd0,  10'd0);
    cmd(OP_BIT,   32'h0,         6'd0,  10'd0);
    // zero capacity, then capacity above the buffer size
    set_capacity(11'd0);
    cmd(OP_CLEAR, 32'h0,         6'd0,  10'd0);
    cmd(OP_BIT,   32'h0,         6'd0,  10'd0);
    set_capacity(11'd2047);
    cmd(OP_LONG,  32'hDEAD_BEEF, 6'd0,  10'd0);
    // capacity lowered below the used count
    set_capacity(11'd2);
    cmd(OP_BYTE,  32'h11,        6'd0,  10'd0);
    cmd(OP_READ,  32'h0,         6'd0,  10'd3);

    // Random phases, one capacity each
    foreach (caps[p]) begin
      set_capacity(caps[p]);
      if (p == 6) begin
        cmd(OP_CLEAR, 32'h0, 6'd0, 10'd0);
        repeat (300) random_cmd(1'b1);
      end else begin
        if ($urandom_range(0, 1) == 0) cmd(OP_CLEAR, 32'h0, 6'd0, 10'd0);
        repeat (75) random_cmd(1'b0);
      end
    end

    settle();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
